[rtl/core/smab_pkg.sv]
// shared constants, beat types and arithmetic helpers for the six-axis averager
// no dependencies; every other file of the block but smab_ram uses this package
package smab_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned WINDOW      = 75;
  localparam int unsigned CAL_COUNT   = 250;
  localparam int unsigned AXES        = 6;

  localparam int unsigned ROW_W  = AXES * SAMPLE_BITS;
  localparam int unsigned PTR_W  = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned CNT_W  = $clog2(CAL_COUNT + 1);

  // window sum and its divide by the window length
  localparam int unsigned SUM_MAG_W    = SAMPLE_BITS - 1 + $clog2(WINDOW + 1);
  localparam int unsigned SUM_W        = SUM_MAG_W + 1;
  localparam int unsigned MEAN_SHIFT   = SUM_MAG_W + $clog2(WINDOW);
  localparam int unsigned MEAN_RECIP_W = SUM_MAG_W + 1;
  localparam int unsigned MEAN_PROD_W  = SUM_MAG_W + MEAN_RECIP_W;
  localparam logic [63:0] MEAN_RECIP_FULL =
    ((64'd1 << MEAN_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = MEAN_RECIP_FULL[MEAN_RECIP_W-1:0];

  // calibration sum and its divide by the calibration length
  localparam int unsigned CAL_SUM_MAG_W = SAMPLE_BITS - 1 + $clog2(CAL_COUNT + 1);
  localparam int unsigned CAL_SUM_W     = CAL_SUM_MAG_W + 1;
  localparam int unsigned CAL_SHIFT     = CAL_SUM_MAG_W + $clog2(CAL_COUNT);
  localparam int unsigned CAL_RECIP_W   = CAL_SUM_MAG_W + 1;
  localparam int unsigned CAL_PROD_W    = CAL_SUM_MAG_W + CAL_RECIP_W;
  localparam int unsigned CAL_QUOT_W    = CAL_SUM_MAG_W + 1 - $clog2(CAL_COUNT);
  localparam logic [63:0] CAL_RECIP_FULL =
    ((64'd1 << CAL_SHIFT) + 64'(CAL_COUNT) - 64'd1) / 64'(CAL_COUNT);
  localparam logic [CAL_RECIP_W-1:0] CAL_RECIP = CAL_RECIP_FULL[CAL_RECIP_W-1:0];

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SAMPLE_BITS:0]   diff_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef sum_t [AXES-1:0]               sum_vec_t;
  typedef logic signed [CAL_SUM_W-1:0]   cal_sum_t;
  typedef logic signed [CAL_QUOT_W:0]    bias_wide_t;
  typedef logic [CNT_W-1:0]              cal_cnt_t;
  typedef logic [PTR_W-1:0]              ptr_t;
  typedef logic [FILL_W-1:0]             fill_t;
  typedef logic [ROW_W-1:0]              window_row_t;

  localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
  localparam sample_t SAMPLE_MIN = sample_t'({1'b1, {(SAMPLE_BITS - 1){1'b0}}});

  typedef enum logic {
    KIND_SAMPLE    = 1'b0,
    KIND_CALIBRATE = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e   kind;
    sample_t force_x;
    sample_t force_y;
    sample_t force_z;
    sample_t torque_x;
    sample_t torque_y;
    sample_t torque_z;
  } in_beat_t;

  typedef struct packed {
    sample_t mean_force_x;
    sample_t mean_force_y;
    sample_t mean_force_z;
    sample_t mean_torque_x;
    sample_t mean_torque_y;
    sample_t mean_torque_z;
    logic    calibrating;
    logic    bias_valid;
  } out_beat_t;

  // one item leaving the window stage
  typedef struct packed {
    logic     valid;
    kind_e    kind;
    logic     produce;
    sum_vec_t sums;
  } acc_beat_t;

  function automatic sample_t neg_sat(sample_t v);
    sample_t r;
    if (v == SAMPLE_MIN) begin
      r = SAMPLE_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  function automatic sum_t ext_sum(sample_t v);
    return {{(SUM_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
  endfunction

  function automatic cal_sum_t ext_cal(sample_t v);
    return {{(CAL_SUM_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
  endfunction

  function automatic diff_t ext_diff(sample_t v);
    return {v[SAMPLE_BITS-1], v};
  endfunction

  function automatic sample_t sat_diff(diff_t v);
    sample_t r;
    if (v[SAMPLE_BITS] == v[SAMPLE_BITS-1]) begin
      r = v[SAMPLE_BITS-1:0];
    end else if (v[SAMPLE_BITS]) begin
      r = SAMPLE_MIN;
    end else begin
      r = SAMPLE_MAX;
    end
    return r;
  endfunction

  function automatic sample_t sat_bias(bias_wide_t v);
    logic [CAL_QUOT_W-SAMPLE_BITS+1:0] top;
    sample_t r;
    top = v[CAL_QUOT_W:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      r = v[SAMPLE_BITS-1:0];
    end else if (v[CAL_QUOT_W]) begin
      r = SAMPLE_MIN;
    end else begin
      r = SAMPLE_MAX;
    end
    return r;
  endfunction

endpackage

[rtl/core/smab_if.sv]
// valid/ready channel interfaces for sample beats and result beats
// depends on smab_pkg for the payload types
interface smab_in_if;
  logic                valid;
  logic                ready;
  smab_pkg::in_beat_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface smab_out_if;
  logic                valid;
  logic                ready;
  smab_pkg::out_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/smab_ram.sv]
// generic single write port ram with one registered read port
// no dependencies
module smab_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/smab_accum.sv]
// input register, axis negation, window memory and running window sums
// depends on smab_pkg and smab_ram
module smab_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                take_i,
  input  smab_pkg::in_beat_t  beat_i,
  output smab_pkg::acc_beat_t acc_o
);

  smab_pkg::sample_t     a_samp_d [smab_pkg::AXES];
  smab_pkg::sample_t     a_samp_q [smab_pkg::AXES];
  logic                  a_valid_q;
  smab_pkg::kind_e       a_kind_q;
  smab_pkg::ptr_t        a_addr_q;
  smab_pkg::ptr_t        rd_ptr_q;
  smab_pkg::ptr_t        rd_ptr_d;
  smab_pkg::window_row_t wr_row;
  smab_pkg::window_row_t rd_row;
  smab_pkg::sample_t     old_samp [smab_pkg::AXES];
  smab_pkg::sum_t        sums_q [smab_pkg::AXES];
  smab_pkg::sum_t        sums_d [smab_pkg::AXES];
  smab_pkg::fill_t       fill_q;
  smab_pkg::fill_t       fill_d;
  logic                  win_full;
  logic                  a_commit;
  logic                  b_valid_q;
  smab_pkg::kind_e       b_kind_q;
  logic                  b_produce_q;
  smab_pkg::sum_vec_t    b_sums_q;

  // y and z of force and torque are flipped on the way in
  always_comb begin
    a_samp_d[0] = beat_i.force_x;
    a_samp_d[1] = smab_pkg::neg_sat(beat_i.force_y);
    a_samp_d[2] = smab_pkg::neg_sat(beat_i.force_z);
    a_samp_d[3] = beat_i.torque_x;
    a_samp_d[4] = smab_pkg::neg_sat(beat_i.torque_y);
    a_samp_d[5] = smab_pkg::neg_sat(beat_i.torque_z);
  end

  assign rd_ptr_d = (rd_ptr_q == smab_pkg::ptr_t'(smab_pkg::WINDOW - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      rd_ptr_q  <= '0;
    end else if (adv_i) begin
      a_valid_q <= take_i;
      if (take_i && beat_i.kind == smab_pkg::KIND_SAMPLE) begin
        rd_ptr_q <= rd_ptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      a_kind_q <= beat_i.kind;
      a_addr_q <= rd_ptr_q;
      for (int a = 0; a < smab_pkg::AXES; a++) begin
        a_samp_q[a] <= a_samp_d[a];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < smab_pkg::AXES; a++) begin
      wr_row[a*smab_pkg::SAMPLE_BITS +: smab_pkg::SAMPLE_BITS] = a_samp_q[a];
      old_samp[a] = rd_row[a*smab_pkg::SAMPLE_BITS +: smab_pkg::SAMPLE_BITS];
    end
  end

  assign a_commit = adv_i && a_valid_q && (a_kind_q == smab_pkg::KIND_SAMPLE);

  // the entry read at accept is the sample that drops out of the window
  smab_ram #(
    .Width (smab_pkg::ROW_W),
    .Depth (smab_pkg::WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (a_commit),
    .waddr_i (a_addr_q),
    .wdata_i (wr_row),
    .re_i    (adv_i),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_row)
  );

  assign win_full = (fill_q == smab_pkg::fill_t'(smab_pkg::WINDOW));
  assign fill_d   = win_full ? fill_q : fill_q + 1'b1;

  always_comb begin
    for (int a = 0; a < smab_pkg::AXES; a++) begin
      sums_d[a] = sums_q[a] + smab_pkg::ext_sum(a_samp_q[a])
                - (win_full ? smab_pkg::ext_sum(old_samp[a]) : smab_pkg::sum_t'(0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      for (int a = 0; a < smab_pkg::AXES; a++) begin
        sums_q[a] <= '0;
      end
    end else if (a_commit) begin
      fill_q <= fill_d;
      for (int a = 0; a < smab_pkg::AXES; a++) begin
        sums_q[a] <= sums_d[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      b_produce_q <= 1'b0;
    end else if (adv_i) begin
      b_valid_q   <= a_valid_q;
      b_produce_q <= a_valid_q && (a_kind_q == smab_pkg::KIND_SAMPLE)
                     && (fill_q >= smab_pkg::fill_t'(smab_pkg::WINDOW - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_kind_q <= a_kind_q;
      for (int a = 0; a < smab_pkg::AXES; a++) begin
        b_sums_q[a] <= sums_d[a];
      end
    end
  end

  always_comb begin
    acc_o.valid   = b_valid_q;
    acc_o.kind    = b_kind_q;
    acc_o.produce = b_produce_q;
    acc_o.sums    = b_sums_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= smab_pkg::fill_t'(smab_pkg::WINDOW))
    else $error("window fill count beyond window length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rd_ptr_q) < smab_pkg::WINDOW)
    else $error("window read pointer out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_commit |-> (a_addr_q != rd_ptr_q))
    else $error("window write and read hit the same entry");

endmodule

[rtl/core/smab_calib.sv]
// window mean by reciprocal multiply, bias calibration and result register
// depends on smab_pkg
module smab_calib (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  smab_pkg::acc_beat_t acc_i,
  output logic                res_valid_o,
  output smab_pkg::out_beat_t res_beat_o
);

  // mean stage
  smab_pkg::sum_t                        sum_neg  [smab_pkg::AXES];
  logic [smab_pkg::SUM_MAG_W-1:0]        sum_mag  [smab_pkg::AXES];
  logic [smab_pkg::MEAN_PROD_W-1:0]      mean_prod [smab_pkg::AXES];
  logic [smab_pkg::SAMPLE_BITS-1:0]      c_quot_q [smab_pkg::AXES];
  logic [smab_pkg::AXES-1:0]             c_neg_q;
  logic                                  c_valid_q;
  logic                                  c_produce_q;
  smab_pkg::kind_e                       c_kind_q;

  // calibration stage
  smab_pkg::diff_t                       mean_wide [smab_pkg::AXES];
  smab_pkg::sample_t                     mean_d   [smab_pkg::AXES];
  smab_pkg::sample_t                     d_mean_q [smab_pkg::AXES];
  smab_pkg::cal_sum_t                    cal_sums_q [smab_pkg::AXES];
  smab_pkg::cal_sum_t                    cal_sums_d [smab_pkg::AXES];
  smab_pkg::cal_cnt_t                    cal_cnt_q;
  smab_pkg::cal_cnt_t                    cal_cnt_d;
  logic                                  cal_active_q;
  logic                                  cal_active_d;
  logic                                  bias_ready_q;
  logic                                  bias_ready_d;
  logic                                  done_d;
  logic                                  d_valid_q;
  logic                                  d_done_q;
  logic                                  d_calibrating_q;
  logic                                  d_bias_valid_q;

  // result stage
  smab_pkg::cal_sum_t                    cal_neg  [smab_pkg::AXES];
  logic [smab_pkg::CAL_SUM_MAG_W-1:0]    cal_mag  [smab_pkg::AXES];
  logic [smab_pkg::CAL_PROD_W-1:0]       cal_prod [smab_pkg::AXES];
  logic [smab_pkg::CAL_QUOT_W-1:0]       cal_quot [smab_pkg::AXES];
  smab_pkg::bias_wide_t                  bias_wide [smab_pkg::AXES];
  smab_pkg::sample_t                     bias_d   [smab_pkg::AXES];
  smab_pkg::sample_t                     bias_q   [smab_pkg::AXES];
  smab_pkg::sample_t                     res_d    [smab_pkg::AXES];
  logic                                  res_valid_q;
  smab_pkg::out_beat_t                   res_beat_q;

  // truncating divide by the window length on the magnitude
  always_comb begin
    for (int a = 0; a < smab_pkg::AXES; a++) begin
      sum_neg[a] = -acc_i.sums[a];
      sum_mag[a] = acc_i.sums[a][smab_pkg::SUM_W-1] ? sum_neg[a][smab_pkg::SUM_MAG_W-1:0]
                                                    : acc_i.sums[a][smab_pkg::SUM_MAG_W-1:0];
      mean_prod[a] = smab_pkg::MEAN_PROD_W'(sum_mag[a])
                   * smab_pkg::MEAN_PROD_W'(smab_pkg::MEAN_RECIP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      c_produce_q <= 1'b0;
    end else if (adv_i) begin
      c_valid_q   <= acc_i.valid;
      c_produce_q <= acc_i.produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_kind_q <= acc_i.kind;
      for (int a = 0; a < smab_pkg::AXES; a++) begin
        c_quot_q[a] <= mean_prod[a][smab_pkg::MEAN_SHIFT +: smab_pkg::SAMPLE_BITS];
        c_neg_q[a]  <= acc_i.sums[a][smab_pkg::SUM_W-1];
      end
    end
  end

  always_comb begin
    cal_cnt_d    = cal_cnt_q;
    cal_active_d = cal_active_q;
    bias_ready_d = bias_ready_q;
    done_d       = 1'b0;
    for (int a = 0; a < smab_pkg::AXES; a++) begin
      mean_wide[a] = c_neg_q[a] ? -smab_pkg::diff_t'({1'b0, c_quot_q[a]})
                                : smab_pkg::diff_t'({1'b0, c_quot_q[a]});
      mean_d[a]     = mean_wide[a][smab_pkg::SAMPLE_BITS-1:0];
      cal_sums_d[a] = cal_sums_q[a];
    end
    if (c_valid_q) begin
      if (c_kind_q == smab_pkg::KIND_CALIBRATE) begin
        cal_cnt_d    = '0;
        cal_active_d = 1'b1;
        for (int a = 0; a < smab_pkg::AXES; a++) begin
          cal_sums_d[a] = '0;
        end
      end else if (c_produce_q && cal_active_q) begin
        cal_cnt_d = cal_cnt_q + 1'b1;
        for (int a = 0; a < smab_pkg::AXES; a++) begin
          cal_sums_d[a] = cal_sums_q[a] + smab_pkg::ext_cal(mean_d[a]);
        end
        if (cal_cnt_q == smab_pkg::cal_cnt_t'(smab_pkg::CAL_COUNT - 1)) begin
          cal_active_d = 1'b0;
          bias_ready_d = 1'b1;
          done_d       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_cnt_q       <= '0;
      cal_active_q    <= 1'b0;
      bias_ready_q    <= 1'b0;
      d_valid_q       <= 1'b0;
      d_done_q        <= 1'b0;
      d_calibrating_q <= 1'b0;
      d_bias_valid_q  <= 1'b0;
      for (int a = 0; a < smab_pkg::AXES; a++) begin
        cal_sums_q[a] <= '0;
      end
    end else if (adv_i) begin
      cal_cnt_q       <= cal_cnt_d;
      cal_active_q    <= cal_active_d;
      bias_ready_q    <= bias_ready_d;
      d_valid_q       <= c_valid_q && (c_kind_q == smab_pkg::KIND_SAMPLE) && c_produce_q;
      d_done_q        <= done_d;
      d_calibrating_q <= cal_active_d;
      d_bias_valid_q  <= bias_ready_d;
      for (int a = 0; a < smab_pkg::AXES; a++) begin
        cal_sums_q[a] <= cal_sums_d[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int a = 0; a < smab_pkg::AXES; a++) begin
        d_mean_q[a] <= mean_d[a];
      end
    end
  end

  // new bias from the finished calibration sums, old bias still applied here
  always_comb begin
    for (int a = 0; a < smab_pkg::AXES; a++) begin
      cal_neg[a]  = -cal_sums_q[a];
      cal_mag[a]  = cal_sums_q[a][smab_pkg::CAL_SUM_W-1]
                  ? cal_neg[a][smab_pkg::CAL_SUM_MAG_W-1:0]
                  : cal_sums_q[a][smab_pkg::CAL_SUM_MAG_W-1:0];
      cal_prod[a] = smab_pkg::CAL_PROD_W'(cal_mag[a])
                  * smab_pkg::CAL_PROD_W'(smab_pkg::CAL_RECIP);
      cal_quot[a] = cal_prod[a][smab_pkg::CAL_SHIFT +: smab_pkg::CAL_QUOT_W];
      bias_wide[a] = cal_sums_q[a][smab_pkg::CAL_SUM_W-1]
                   ? -smab_pkg::bias_wide_t'({1'b0, cal_quot[a]})
                   : smab_pkg::bias_wide_t'({1'b0, cal_quot[a]});
      bias_d[a] = smab_pkg::sat_bias(bias_wide[a]);
      res_d[a]  = smab_pkg::sat_diff(smab_pkg::ext_diff(d_mean_q[a])
                                   - smab_pkg::ext_diff(bias_q[a]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      for (int a = 0; a < smab_pkg::AXES; a++) begin
        bias_q[a] <= '0;
      end
    end else if (adv_i) begin
      res_valid_q <= d_valid_q;
      if (d_valid_q && d_done_q) begin
        for (int a = 0; a < smab_pkg::AXES; a++) begin
          bias_q[a] <= bias_d[a];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_beat_q.mean_force_x  <= res_d[0];
      res_beat_q.mean_force_y  <= res_d[1];
      res_beat_q.mean_force_z  <= res_d[2];
      res_beat_q.mean_torque_x <= res_d[3];
      res_beat_q.mean_torque_y <= res_d[4];
      res_beat_q.mean_torque_z <= res_d[5];
      res_beat_q.calibrating   <= d_calibrating_q;
      res_beat_q.bias_valid    <= d_bias_valid_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_beat_o  = res_beat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_active_q |-> (cal_cnt_q < smab_pkg::cal_cnt_t'(smab_pkg::CAL_COUNT)))
    else $error("calibration count ran past its end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_valid_q && d_done_q) |-> (d_bias_valid_q && !d_calibrating_q))
    else $error("flags of the completing beat are wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(bias_q[0]) |-> $past(adv_i && d_valid_q && d_done_q))
    else $error("bias changed without a completed calibration");

endmodule

[rtl/core/six_axis_moving_average_bias.sv]
// Six-axis force/torque boxcar averager with bias calibration. Sample beats
// enter on sample_i and result beats leave on result_o; one beat is taken
// every cycle and the pipeline only holds when the result register is full
// and not taken. A sample passes five registers (input, window sum, divide,
// calibration, result) before it leaves on result_o; the rate of one beat per
// cycle is set by the single read and write of the window memory per sample.
// y and z axes are negated with saturation. No result is given until the window
// holds WINDOW samples; the window memory needs no clearing pass after reset
// since the fill count masks unwritten entries. A calibrate beat gives no result
// and makes the next CAL_COUNT results collect their raw means into new biases,
// which apply from the sample after the one that completes the calibration.
// depends on smab_pkg, smab_if, smab_accum and smab_calib
module six_axis_moving_average_bias (
  input  logic       clk_i,
  input  logic       rst_ni,
  smab_in_if.sink    sample_i,
  smab_out_if.source result_o
);

  logic                adv;
  logic                take;
  smab_pkg::acc_beat_t acc;
  logic                res_valid;
  smab_pkg::out_beat_t res_beat;

  // whole pipeline moves in lockstep with the result register
  assign adv            = !res_valid || result_o.ready;
  assign sample_i.ready = adv;
  assign take           = sample_i.valid && adv;

  smab_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .take_i (take),
    .beat_i (sample_i.payload),
    .acc_o  (acc)
  );

  smab_calib u_calib (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .acc_i       (acc),
    .res_valid_o (res_valid),
    .res_beat_o  (res_beat)
  );

  assign result_o.valid   = res_valid;
  assign result_o.payload = res_beat;

endmodule

[tb/smab_mean_check.sv]
`timescale 1ns / 100ps
// result predictor and comparator for the six-axis moving average with bias
// watches both channels; depends on smab_pkg and smab_if
module smab_mean_check
  import smab_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  smab_in_if         sample_ch,
  smab_out_if        result_ch,
  output int         fail_count,
  output int         pending
);

  // predicted filter state
  sample_t     win_rows [WINDOW][AXES];
  int unsigned wr_ptr;
  int unsigned filled;
  longint      axis_sum [AXES];
  longint      bias [AXES];
  longint      cal_sum [AXES];
  int unsigned cal_seen;
  bit          cal_on;
  bit          bias_on;

  out_beat_t   expected_means [$];
  int          fails;

  string field_name [AXES + 2] = '{"mean_force_x", "mean_force_y", "mean_force_z",
    "mean_torque_x", "mean_torque_y", "mean_torque_z", "calibrating", "bias_valid"};

  function automatic sample_t clamp_sample(longint v);
    if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
    if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
    return sample_t'(v);
  endfunction

  function automatic void clear_filter();
    wr_ptr   = 0;
    filled   = 0;
    cal_seen = 0;
    cal_on   = 1'b0;
    bias_on  = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      axis_sum[a] = 0;
      bias[a]     = 0;
      cal_sum[a]  = 0;
    end
  endfunction

  function automatic bit average_step(input in_beat_t b, output out_beat_t r);
    sample_t raw [AXES];
    sample_t res [AXES];
    longint  v;
    longint  mean [AXES];
    longint  prior [AXES];
    r = '0;
    if (b.kind == KIND_CALIBRATE) begin
      for (int a = 0; a < AXES; a++) cal_sum[a] = 0;
      cal_seen = 0;
      cal_on   = 1'b1;
      return 1'b0;
    end
    raw = '{b.force_x, b.force_y, b.force_z, b.torque_x, b.torque_y, b.torque_z};
    for (int a = 0; a < AXES; a++) begin
      v = longint'(raw[a]);
      // y and z of force and torque are flipped
      if ((a % 3) != 0) v = -v;
      if (filled >= WINDOW) axis_sum[a] -= longint'(win_rows[wr_ptr][a]);
      axis_sum[a] += longint'(clamp_sample(v));
      win_rows[wr_ptr][a] = clamp_sample(v);
    end
    wr_ptr = (wr_ptr + 1) % WINDOW;
    if (filled < WINDOW) filled++;
    if (filled < WINDOW) return 1'b0;
    for (int a = 0; a < AXES; a++) begin
      mean[a]  = axis_sum[a] / longint'(WINDOW);
      prior[a] = bias[a];
    end
    if (cal_on) begin
      for (int a = 0; a < AXES; a++) cal_sum[a] += mean[a];
      cal_seen++;
      if (cal_seen >= CAL_COUNT) begin
        for (int a = 0; a < AXES; a++)
          bias[a] = longint'(clamp_sample(cal_sum[a] / longint'(CAL_COUNT)));
        cal_on  = 1'b0;
        bias_on = 1'b1;
      end
    end
    for (int a = 0; a < AXES; a++) res[a] = clamp_sample(mean[a] - prior[a]);
    r.mean_force_x  = res[0];
    r.mean_force_y  = res[1];
    r.mean_force_z  = res[2];
    r.mean_torque_x = res[3];
    r.mean_torque_y = res[4];
    r.mean_torque_z = res[5];
    r.calibrating   = cal_on;
    r.bias_valid    = bias_on;
    return 1'b1;
  endfunction

  function automatic void note_failure(string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endfunction

  function automatic void compare_beat(out_beat_t want, out_beat_t got);
    logic [SAMPLE_BITS-1:0] w [AXES + 2];
    logic [SAMPLE_BITS-1:0] g [AXES + 2];
    {w[0], w[1], w[2], w[3], w[4], w[5]} = want[ROW_W+1:2];
    {g[0], g[1], g[2], g[3], g[4], g[5]} = got[ROW_W+1:2];
    w[6] = SAMPLE_BITS'(want.calibrating);
    w[7] = SAMPLE_BITS'(want.bias_valid);
    g[6] = SAMPLE_BITS'(got.calibrating);
    g[7] = SAMPLE_BITS'(got.bias_valid);
    for (int f = 0; f < AXES + 2; f++) begin
      if (w[f] !== g[f])
        note_failure($sformatf("mismatch on %s: expected %0d, got %0d",
          field_name[f], $signed(w[f]), $signed(g[f])));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_beat_t want;
    if (!rst_ni) begin
      clear_filter();
      expected_means.delete();
      fails = 0;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      // compare before predicting so a fresh beat cannot mask a stray result
      if (result_ch.valid && result_ch.ready) begin
        if (expected_means.size() == 0) begin
          note_failure($sformatf("result beat with nothing expected: %h", result_ch.payload));
        end else begin
          want = expected_means.pop_front();
          compare_beat(want, result_ch.payload);
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        if (average_step(sample_ch.payload, want)) begin
          expected_means.insert(expected_means.size(), want);
        end
      end
      fail_count <= fails;
      pending    <= expected_means.size();
    end
  end

endmodule

[tb/six_axis_moving_average_bias_test.sv]
`timescale 1ns / 100ps
// top of the six-axis moving average testbench: clock, reset, sample and result traffic
// depends on smab_pkg, smab_if, the block and smab_mean_check
module six_axis_moving_average_bias_test;
  import smab_pkg::*;

  typedef enum int {MIX_UNIFORM, MIX_HIGH, MIX_LOW, MIX_SMALL, MIX_EXTREME} mix_e;
  typedef enum int {READY_OPEN, READY_COIN, READY_SHUT} ready_mode_e;

  localparam int RANDOM_ITEMS = 1850;
  localparam int LATENCY      = 5;
  localparam int HOLD_START   = 800;
  localparam int HOLD_CYCLES  = 400;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   burst_left;

  smab_in_if  sample_ch ();
  smab_out_if result_ch ();

  six_axis_moving_average_bias dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch)
  );

  smab_mean_check u_mean_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_ch  (sample_ch),
    .result_ch  (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic sample_t pick_value(mix_e m);
    case (m)
      MIX_HIGH:  return SAMPLE_MAX - sample_t'($urandom_range(0, 1000));
      MIX_LOW:   return SAMPLE_MIN + sample_t'($urandom_range(0, 1000));
      MIX_SMALL: return sample_t'($urandom_range(0, 400)) - sample_t'(200);
      MIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return SAMPLE_MAX;
          1:       return SAMPLE_MIN;
          2:       return sample_t'(0);
          default: return sample_t'(-1);
        endcase
      end
      default:   return sample_t'($urandom);
    endcase
  endfunction

  function automatic in_beat_t make_sample(mix_e m);
    in_beat_t b;
    b.kind     = KIND_SAMPLE;
    b.force_x  = pick_value(m);
    b.force_y  = pick_value(m);
    b.force_z  = pick_value(m);
    b.torque_x = pick_value(m);
    b.torque_y = pick_value(m);
    b.torque_z = pick_value(m);
    return b;
  endfunction

  function automatic in_beat_t level_sample(sample_t v);
    in_beat_t b;
    b.kind     = KIND_SAMPLE;
    b.force_x  = v;
    b.force_y  = v;
    b.force_z  = v;
    b.torque_x = v;
    b.torque_y = v;
    b.torque_z = v;
    return b;
  endfunction

  function automatic in_beat_t calibrate_beat();
    in_beat_t b;
    b      = make_sample(MIX_UNIFORM);
    b.kind = KIND_CALIBRATE;
    return b;
  endfunction

  // sender works in bursts, gaps only fall between bursts
  task automatic offer_beat(input in_beat_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    sample_ch.valid   <= 1'b1;
    sample_ch.payload <= b;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
  endtask

  initial begin : result_side
    ready_mode_e mode;
    int          run;
    int          cycles;
    bit          held;
    result_ch.ready = 1'b0;
    cycles = 0;
    held   = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && cycles >= HOLD_START) begin
        // long hold-off so the pipeline fills and backs up the input
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        cycles += HOLD_CYCLES;
      end else begin
        mode = ready_mode_e'($urandom_range(0, 2));
        run  = (mode == READY_SHUT) ? $urandom_range(1, 8) : $urandom_range(1, 30);
        repeat (run) begin
          case (mode)
            READY_OPEN: result_ch.ready <= 1'b1;
            READY_COIN: result_ch.ready <= 1'($urandom_range(0, 1));
            default:    result_ch.ready <= 1'b0;
          endcase
          @(posedge clk_i);
          cycles++;
        end
      end
    end
  end

  initial begin : sample_side
    in_beat_t b;
    mix_e     mix;
    int       mix_left;
    int       waited;
    rst_ni            = 1'b0;
    sample_ch.valid   = 1'b0;
    sample_ch.payload = '0;
    burst_left = 0;
    mix_left   = 0;
    mix        = MIX_UNIFORM;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, calibrate before the window fills, restart
    offer_beat(calibrate_beat());
    offer_beat(level_sample(SAMPLE_MAX));
    offer_beat(level_sample(SAMPLE_MIN));
    offer_beat(level_sample(sample_t'(0)));
    offer_beat(level_sample(sample_t'(-1)));
    offer_beat(calibrate_beat());
    offer_beat(calibrate_beat());
    offer_beat(level_sample(sample_t'(1)));
    offer_beat(level_sample(SAMPLE_MIN + sample_t'(1)));
    b = level_sample(SAMPLE_MIN);
    b.force_x  = SAMPLE_MAX;
    b.torque_x = SAMPLE_MAX;
    offer_beat(b);
    b = level_sample(SAMPLE_MAX);
    b.force_y  = SAMPLE_MIN;
    b.torque_z = SAMPLE_MIN;
    offer_beat(b);

    // random: segments of similar values so means and biases reach the rails
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (mix_left == 0) begin
        mix      = mix_e'($urandom_range(0, 4));
        mix_left = $urandom_range(40, 250);
      end
      mix_left--;
      if (i == 150 || i == 900 || i == 1500 || $urandom_range(0, 699) == 0) begin
        offer_beat(calibrate_beat());
      end else begin
        offer_beat(make_sample(mix));
      end
    end
    sample_ch.valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4 * LATENCY) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
